### sv/gtc_pkg.sv
package gtc_pkg;

  // Field and state widths.
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 23;
  localparam int TargetW  = 13;
  localparam int LimitW   = 23;
  localparam int AngleW   = 40;
  localparam int TimeW    = 24;
  localparam int GoalW    = 33;
  localparam int ProdW    = 32;
  localparam int NumW     = 41;
  localparam int QuoW     = 8;
  localparam int DivSteps = 8;
  localparam int DivCntW  = 3;

  // Command codes of an input request.
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_TARGET = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_LIMIT  = 1'b1;

  // Reset values and fixed constants.
  localparam logic [TargetW-1:0] TARGET_RST  = 13'd1440;
  localparam logic [LimitW-1:0]  LIMIT_RST   = 23'd1500000;
  localparam logic [19:0]        US_PER_S    = 20'd1000000;
  localparam logic [7:0]         MIN_SPEED   = 8'd10;
  localparam logic [7:0]         START_SPEED = 8'd225;

  // Kind of result that the controller asks the datapath to present.
  localparam logic [1:0] RES_IDLE  = 2'd0;
  localparam logic [1:0] RES_START = 2'd1;
  localparam logic [1:0] RES_END   = 2'd2;
  localparam logic [1:0] RES_SPEED = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] gyro_rate;
    logic [15:0]        dt_us;
  } gtc_in_t;

  typedef struct packed {
    logic [7:0] motor_speed;
    logic       clockwise_drive;
    logic       turning;
    logic       turn_done;
  } gtc_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load_in;
    logic       start;
    logic       mul;
    logic       acc;
    logic       stop;
    logic       diff;
    logic       prep;
    logic       div_step;
    logic       out_load;
    logic [1:0] kind;
  } gtc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_sample;
    logic active;
    logic target_zero;
    logic end_hit;
  } gtc_stat_t;

endpackage

### sv/gyro_turn_controller_top.sv
// Gyro turn controller: turns a two-motor robot in place, clockwise, by the
// configured target angle. A start request clears the turned angle and the
// elapsed time and drives speed 225, or ends the turn at once if the target
// is zero; each gyro sample during a turn integrates |rate| * dt and either
// ends the turn (speed 0, turn_done) or drives a speed proportional to the
// remaining angle, clamped to 10..255. One request is handled at a time. A
// start request, or a sample while idle, goes from decode straight to the
// output register; a sample that ends the turn first accumulates and checks;
// any other sample also runs the 8-step serial divider that forms the speed.
// The next request is accepted in the cycle after the result is loaded. The
// output register lets the next request be accepted while a result still waits.
// Configuration writes are always accepted and must only be made while idle.
module gyro_turn_controller_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  gtc_pkg::gtc_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output gtc_pkg::gtc_out_t            out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gtc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gtc_pkg::CfgDataW-1:0] cfg_data_i
);
  import gtc_pkg::*;

  gtc_cmd_t  cmd;
  gtc_stat_t stat;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready_o = 1'b1;

  gtc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gtc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

### sv/gtc_ctrl.sv
module gtc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  gtc_pkg::gtc_stat_t stat_i,
  output gtc_pkg::gtc_cmd_t  cmd_o
);
  import gtc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_ACC    = 3'd2;
  localparam logic [2:0] S_CHK    = 3'd3;
  localparam logic [2:0] S_PREP   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [1:0]         kind_q, kind_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic               out_valid_q, out_valid_d;

  // Sequencer for one request.
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = kind_q;
    state_d    = state_q;
    kind_d     = kind_q;
    div_cnt_d  = div_cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat_i.is_sample) begin
          cmd_o.start = 1'b1;
          kind_d      = stat_i.target_zero ? RES_END : RES_START;
          state_d     = S_OUT;
        end else if (!stat_i.active) begin
          kind_d  = RES_IDLE;
          state_d = S_OUT;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        if (stat_i.end_hit) begin
          cmd_o.stop = 1'b1;
          kind_d     = RES_END;
          state_d    = S_OUT;
        end else begin
          cmd_o.diff = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        div_cnt_d  = '0;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + 1'b1;
        if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
          kind_d  = RES_SPEED;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output register is freed when its request is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= RES_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while waiting");

  // The divider always starts its step count from zero.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PREP) |=> (state_q == S_DIV && div_cnt_q == '0))
    else $error("divider entered with a stale count");

endmodule

### sv/gtc_datapath.sv
module gtc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gtc_pkg::gtc_in_t              in_data_i,
  input  logic                          cfg_we_i,
  input  logic [gtc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gtc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  gtc_pkg::gtc_cmd_t             cmd_i,
  output gtc_pkg::gtc_stat_t            stat_o,
  output gtc_pkg::gtc_out_t             out_data_o
);
  import gtc_pkg::*;

  // Configuration and turn state.
  logic [TargetW-1:0] target_q;
  logic [LimitW-1:0]  limit_q;
  logic               active_q;
  logic [AngleW-1:0]  turned_q;
  logic [TimeW-1:0]   elapsed_q;

  // Working registers.
  gtc_in_t            in_q;
  logic [ProdW-1:0]   prod_q;
  logic [GoalW-1:0]   goal_q;
  logic [GoalW-1:0]   diff_q;
  logic [NumW-1:0]    rem_q;
  logic [NumW-2:0]    dvs_q;
  logic [QuoW-1:0]    quo_q;
  gtc_out_t           out_q;

  logic signed [16:0] rate_ext;
  logic [16:0]        mag;
  logic [AngleW:0]    turned_sum;
  logic [TimeW:0]     elapsed_sum;
  logic [NumW-1:0]    num;
  logic               rem_ge;
  logic [QuoW-1:0]    speed;
  gtc_out_t           res;

  // Rate magnitude, 0 to 32768.
  assign rate_ext = {in_q.gyro_rate[15], in_q.gyro_rate};
  assign mag      = in_q.gyro_rate[15] ? 17'(-rate_ext) : 17'(rate_ext);

  // Saturating sums.
  assign turned_sum  = {1'b0, turned_q} + (AngleW + 1)'(prod_q);
  assign elapsed_sum = {1'b0, elapsed_q} + (TimeW + 1)'(in_q.dt_us);

  // Numerator 255 * (goal - turned) as a shift and subtract.
  assign num    = {diff_q, 8'b0} - NumW'(diff_q);
  assign rem_ge = (rem_q >= {1'b0, dvs_q});

  // Clamp the quotient from below; it never exceeds 255.
  assign speed = (quo_q < MIN_SPEED) ? MIN_SPEED : quo_q;

  assign stat_o.is_sample   = (in_q.cmd == CMD_SAMPLE);
  assign stat_o.active      = active_q;
  assign stat_o.target_zero = (target_q == '0);
  assign stat_o.end_hit     = (turned_q >= AngleW'(goal_q)) ||
                              (elapsed_q >= TimeW'(limit_q));

  // Result selection.
  always_comb begin
    res = '0;
    unique case (cmd_i.kind)
      RES_IDLE: begin
        res = '0;
      end
      RES_START: begin
        res.motor_speed     = START_SPEED;
        res.clockwise_drive = 1'b1;
        res.turning         = 1'b1;
      end
      RES_END: begin
        res.clockwise_drive = 1'b1;
        res.turn_done       = 1'b1;
      end
      RES_SPEED: begin
        res.motor_speed     = speed;
        res.clockwise_drive = 1'b1;
        res.turning         = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Configuration registers and turn state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= TARGET_RST;
      limit_q   <= LIMIT_RST;
      active_q  <= 1'b0;
      turned_q  <= '0;
      elapsed_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_TARGET: target_q <= cfg_data_i[TargetW-1:0];
          REG_LIMIT:  limit_q  <= cfg_data_i[LimitW-1:0];
          default:    target_q <= target_q;
        endcase
      end
      if (cmd_i.start) begin
        turned_q  <= '0;
        elapsed_q <= '0;
        active_q  <= (target_q != '0);
      end
      if (cmd_i.acc) begin
        turned_q  <= turned_sum[AngleW] ? '1 : turned_sum[AngleW-1:0];
        elapsed_q <= elapsed_sum[TimeW] ? '1 : elapsed_sum[TimeW-1:0];
      end
      if (cmd_i.stop) begin
        active_q <= 1'b0;
      end
    end
  end

  // Product, goal, restoring divider and output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(mag) * ProdW'(in_q.dt_us);
      goal_q <= GoalW'(target_q) * GoalW'(US_PER_S);
    end
    if (cmd_i.diff) begin
      diff_q <= goal_q - turned_q[GoalW-1:0];
    end
    if (cmd_i.prep) begin
      rem_q <= num;
      dvs_q <= {goal_q, 7'b0};
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - {1'b0, dvs_q};
      end
      quo_q <= {quo_q[QuoW-2:0], rem_ge};
      dvs_q <= dvs_q >> 1;
    end
    if (cmd_i.out_load) begin
      out_q <= res;
    end
  end

  assign out_data_o = out_q;

  // Ending a turn always leaves the block idle.
  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.stop |=> !active_q)
    else $error("turn still active after its end");

  // The finished division leaves a remainder below the goal.
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && cmd_i.kind == RES_SPEED) |-> (rem_q < NumW'(goal_q)))
    else $error("speed division left a remainder out of range");

endmodule
